[design/lsra_pkg.sv]
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared types for the linear scan register allocator chain.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // Control that rides with an item down the chain of cells
    typedef struct packed {
        logic valid;    // an item sits in this stage
        logic new_fn;   // clear allocation state as the item passes
        logic claimed;  // a register has already been taken upstream
    } t_tok_ctl;

endpackage

[design/linear_scan_register_allocator_unit.sv]
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_unit
// Linear scan register allocator built as a systolic chain of register cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one live interval per item:
//   new-function flag, start and exclusive end. Intervals are expected in
//   ascending start order. Output channel (o_out_valid / i_out_ready) returns
//   one item per interval: register number, out-of-registers flag and the
//   count of registers handed out so far.
//   Each item walks the chain of MAX_REGS cells, one cell per cycle unless the
//   chain is frozen. In every cell it frees an ended interval and claims the
//   cell if it is the first free one met; each cell registers the item. A
//   following item may enter in the very next cycle, so throughput is one item
//   per cycle while results are taken; order is kept as items never overtake.
//   Unused cells beyond the fresh counter are free, so the lowest free cell
//   is either a released register or the next fresh one.
//   Reset (synchronous, active low) empties the chain and frees every
//   register at once. new_function clears each cell as the item passes it.
//   When the receiver stalls with a result waiting, the whole chain freezes
//   and o_in_ready drops until that result is taken.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit
    import lsra_pkg::*;
#(
    parameter int MAX_REGS = 64,
    parameter int POS_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_new_function,
    input  logic [POS_BITS-1:0] i_interval_start,
    input  logic [POS_BITS-1:0] i_interval_end,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [5:0]          o_assigned_register,
    output logic                o_out_of_registers,
    output logic [6:0]          o_registers_used
);

    localparam int IW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW = $clog2(MAX_REGS + 1);

    // chain links: index 0 is the accepted item, MAX_REGS the finished result
    t_tok_ctl            c_ctl   [MAX_REGS+1];
    logic [POS_BITS-1:0] c_start [MAX_REGS+1];
    logic [POS_BITS-1:0] c_end   [MAX_REGS+1];
    logic [IW-1:0]       c_pick  [MAX_REGS+1];
    logic [CW-1:0]       c_count [MAX_REGS+1];

    logic adv;

    // whole chain moves together; it holds only while a result is refused
    assign adv        = ~c_ctl[MAX_REGS].valid | i_out_ready;
    assign o_in_ready = adv;

    always_comb begin
        c_ctl[0].valid   = i_in_valid & adv;
        c_ctl[0].new_fn  = i_new_function;
        c_ctl[0].claimed = 1'b0;
        c_start[0]       = i_interval_start;
        c_end[0]         = i_interval_end;
        c_pick[0]        = '0;
        c_count[0]       = '0;
    end

    for (genvar g = 0; g < MAX_REGS; g++) begin : g_cell
        lsra_cell #(
            .IDX      (g),
            .POS_BITS (POS_BITS),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (c_ctl[g]),
            .i_start (c_start[g]),
            .i_end   (c_end[g]),
            .i_pick  (c_pick[g]),
            .i_count (c_count[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_start (c_start[g+1]),
            .o_end   (c_end[g+1]),
            .o_pick  (c_pick[g+1]),
            .o_count (c_count[g+1])
        );
    end

    // an item that met no free cell found every register held
    assign o_out_valid         = c_ctl[MAX_REGS].valid;
    assign o_out_of_registers  = ~c_ctl[MAX_REGS].claimed;
    assign o_assigned_register = c_ctl[MAX_REGS].claimed ? 6'(c_pick[MAX_REGS]) : 6'd0;
    assign o_registers_used    = 7'(c_count[MAX_REGS]);

    // exhaustion only once every register has been handed out
    a_exhaust_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_registers |-> o_registers_used == 7'(MAX_REGS))
        else $error("out of registers with registers left");

    // a granted register lies below the used count
    a_pick_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_of_registers |->
            (MAX_REGS > 64) || ({1'b0, o_assigned_register} < o_registers_used))
        else $error("assigned register beyond used count");

    // a refused result freezes the chain
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result stalled");

    // reset empties the chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

[design/lsra_cell.sv]
// ----------------------------------------------------------------------------
// lsra_cell
// One register of the allocator: busy and used flags, the end position held,
// and one pipeline stage of the item travelling through the chain.
// ----------------------------------------------------------------------------
module lsra_cell
    import lsra_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int POS_BITS = 20,
    parameter int IW       = 6,
    parameter int CW       = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  t_tok_ctl            i_ctl,
    input  logic [POS_BITS-1:0] i_start,
    input  logic [POS_BITS-1:0] i_end,
    input  logic [IW-1:0]       i_pick,
    input  logic [CW-1:0]       i_count,
    output t_tok_ctl            o_ctl,
    output logic [POS_BITS-1:0] o_start,
    output logic [POS_BITS-1:0] o_end,
    output logic [IW-1:0]       o_pick,
    output logic [CW-1:0]       o_count
);

    localparam logic [IW-1:0] CellId = IW'(IDX);

    logic                r_busy, n_busy;
    logic                r_used, n_used;
    logic [POS_BITS-1:0] r_end_pos;
    t_tok_ctl            r_ctl, n_ctl;
    logic [POS_BITS-1:0] r_start, r_end;
    logic [IW-1:0]       r_pick, n_pick;
    logic [CW-1:0]       r_count, n_count;

    logic clr, busy_c, used_c, busy_r, take;

    always_comb begin
        clr     = i_ctl.valid & i_ctl.new_fn;
        busy_c  = r_busy & ~clr;
        used_c  = r_used & ~clr;
        // release when the held interval ended at or before the new start
        busy_r  = busy_c & ~(r_end_pos <= i_start);
        take    = i_ctl.valid & ~i_ctl.claimed & ~busy_r;
        n_busy  = i_ctl.valid ? (busy_r | take) : r_busy;
        n_used  = i_ctl.valid ? (used_c | take) : r_used;
        n_ctl   = i_ctl;
        n_ctl.claimed = i_ctl.claimed | take;
        n_pick  = take ? CellId : i_pick;
        // used cells form a prefix, so their count is the fresh counter
        n_count = i_count + CW'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_used <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_busy <= n_busy;
            r_used <= n_used;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_start <= i_start;
            r_end   <= i_end;
            r_pick  <= n_pick;
            r_count <= n_count;
            if (take) begin
                r_end_pos <= i_end;
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_pick  = r_pick;
    assign o_count = r_count;

endmodule

[verif/linear_scan_register_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_unit_tb
// Self-checking bench for the linear scan register allocator. A queue-fed
// driver sends live intervals. A monitor checks every returned item against a
// behavioural allocator that is updated as each interval is accepted. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREGS     = 64;
    localparam int PW        = 20;
    localparam int POS_MAX   = (1 << PW) - 1;
    localparam int N_ITEMS   = 1800;
    localparam int REPORT_MAX = 10;

    // One live interval as it enters the block
    typedef struct packed {
        logic          new_fn;
        logic [PW-1:0] first_pos;   // start, inclusive
        logic [PW-1:0] last_pos;    // end, exclusive
    } t_interval;

    // One allocation result as it leaves the block
    typedef struct packed {
        logic [5:0] reg_num;
        logic       oor;
        logic [6:0] used;
    } t_grant;

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic          i_clk            = 1'b0;
    logic          i_rst_n          = 1'b0;
    logic          i_in_valid       = 1'b0;
    logic          i_new_function   = 1'b0;
    logic [PW-1:0] i_interval_start = '0;
    logic [PW-1:0] i_interval_end   = '0;
    logic          i_out_ready      = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [5:0]    o_assigned_register;
    logic          o_out_of_registers;
    logic [6:0]    o_registers_used;

    always #6 i_clk = ~i_clk;

    linear_scan_register_allocator_unit #(
        .MAX_REGS (NREGS),
        .POS_BITS (PW)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_new_function      (i_new_function),
        .i_interval_start    (i_interval_start),
        .i_interval_end      (i_interval_end),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_assigned_register (o_assigned_register),
        .o_out_of_registers  (o_out_of_registers),
        .o_registers_used    (o_registers_used)
    );

    // ------------------------------------------------------------------------
    // Allocator state mirrored by the bench
    // ------------------------------------------------------------------------
    logic          reg_held [NREGS];
    logic [PW-1:0] reg_ends [NREGS];
    int unsigned   fresh_cnt;

    t_interval pend_q[$];       // intervals waiting to be sent
    t_grant    grant_q[$];      // allocations still to come back
    int unsigned mismatch_cnt = 0;

    initial begin
        foreach (reg_held[r]) reg_held[r] = 1'b0;
        fresh_cnt = 0;
    end

    // Free ended intervals, then take the lowest free register or a fresh one.
    // Only held entries are ever compared, so stale end positions never matter.
    function automatic t_grant allocate_interval(t_interval iv);
        t_grant      g;
        int unsigned pick;
        bit          found;
        pick  = 0;
        found = 1'b0;
        if (iv.new_fn) begin
            foreach (reg_held[r]) reg_held[r] = 1'b0;
            fresh_cnt = 0;
        end
        for (int r = 0; r < fresh_cnt; r++) begin
            if (reg_held[r] && reg_ends[r] <= iv.first_pos) reg_held[r] = 1'b0;
        end
        for (int r = 0; r < fresh_cnt; r++) begin
            if (!reg_held[r]) begin
                pick  = r;
                found = 1'b1;
                break;
            end
        end
        if (!found && fresh_cnt < NREGS) begin
            pick  = fresh_cnt;
            fresh_cnt++;
            found = 1'b1;
        end
        if (found) begin
            reg_held[pick] = 1'b1;
            reg_ends[pick] = iv.last_pos;
        end
        g.reg_num = found ? pick[5:0] : 6'd0;
        g.oor     = ~found;
        g.used    = fresh_cnt[6:0];
        return g;
    endfunction

    // Idle length: mostly none or short, now and then long; none in calm spells
    function automatic int unsigned pick_gap(bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: valid held with a steady payload until the item is taken
    // ------------------------------------------------------------------------
    int unsigned src_gap  = 0;
    bit          src_calm = 1'b0;

    always @(posedge i_clk) begin
        t_interval iv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                iv.new_fn    = i_new_function;
                iv.first_pos = i_interval_start;
                iv.last_pos  = i_interval_end;
                grant_q = {grant_q, allocate_interval(iv)};
            end
            // slot is free when nothing is held or the held item just went
            if (!i_in_valid || o_in_ready) begin
                if ($urandom_range(0, 149) == 0) src_calm = ~src_calm;
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    iv = pend_q.pop_front();
                    i_in_valid       <= 1'b1;
                    i_new_function   <= iv.new_fn;
                    i_interval_start <= iv.first_pos;
                    i_interval_end   <= iv.last_pos;
                    src_gap = pick_gap(src_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, in-order check against the oldest entry
    // ------------------------------------------------------------------------
    int unsigned snk_stall = 0;
    bit          snk_calm  = 1'b0;

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (grant_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display(
                            "%0t: unexpected item reg=%0d oor=%0b used=%0d", $realtime,
                            o_assigned_register, o_out_of_registers, o_registers_used);
                end else begin
                    want = grant_q.pop_front();
                    if (o_assigned_register !== want.reg_num ||
                        o_out_of_registers  !== want.oor ||
                        o_registers_used    !== want.used) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display(
                                "%0t: exp reg=%0d oor=%0b used=%0d got reg=%0d oor=%0b used=%0d",
                                $realtime, want.reg_num, want.oor, want.used,
                                o_assigned_register, o_out_of_registers, o_registers_used);
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) snk_calm = ~snk_calm;
            if (snk_stall > 0) begin
                snk_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) snk_stall = pick_gap(snk_calm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int unsigned queued = 0;

    function automatic void add_interval(logic nf, logic [PW-1:0] s, logic [PW-1:0] e);
        t_interval iv;
        iv.new_fn    = nf;
        iv.first_pos = s;
        iv.last_pos  = e;
        pend_q = {pend_q, iv};
        queued++;
    endfunction

    // One function's worth of intervals: rising starts with random content.
    // Short spans recycle registers, long spans run the pool dry; a few
    // reversed ends and jumps in start are mixed in as noise.
    function automatic void add_function_run();
        int unsigned n_run, flavour, pos, span;
        logic        nf;
        logic [PW-1:0] e;
        n_run   = $urandom_range(8, 110);
        flavour = $urandom_range(0, 9);
        pos     = $urandom_range(0, POS_MAX);
        for (int k = 0; k < n_run; k++) begin
            nf = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 299) == 0);
            if ($urandom_range(0, 49) == 0) pos = $urandom_range(0, POS_MAX);
            else pos = (pos + $urandom_range(0, 3)) & POS_MAX;
            if (flavour < 4)      span = $urandom_range(0, 8);
            else if (flavour < 7) span = $urandom_range(0, 300);
            else                  span = $urandom_range(64, POS_MAX);
            e = PW'(pos + span);
            if ($urandom_range(0, 29) == 0) e = PW'($urandom_range(0, POS_MAX));
            add_interval(nf, PW'(pos), e);
        end
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || i_in_valid || grant_q.size() != 0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state used without a new-function flag
        add_interval(1'b0, 20'd0, 20'd5);
        add_interval(1'b0, 20'd0, 20'd0);             // empty interval
        add_interval(1'b0, 20'd1, 20'd3);             // empty one frees at once
        add_interval(1'b0, 20'd5, POS_MAX);           // end equal to start frees
        add_interval(1'b0, 20'd6, 20'd2);             // reversed interval
        add_interval(1'b0, 20'd3, 20'd10);            // start out of order
        add_interval(1'b0, 20'd3, 20'd10);            // same start again
        add_interval(1'b1, POS_MAX, POS_MAX);         // fresh function, top position
        add_interval(1'b0, POS_MAX, 20'd0);
        add_interval(1'b0, POS_MAX, POS_MAX);
        add_interval(1'b1, 20'd0, POS_MAX);
        add_interval(1'b0, 20'h55555, 20'hAAAAA);
        add_interval(1'b0, 20'hAAAAA, 20'h55555);
        add_interval(1'b1, 20'h00001, 20'h80000);
        add_interval(1'b0, 20'h7FFFF, 20'hFFFFE);
        add_interval(1'b0, 20'h80000, 20'h80000);
        wait_drained();

        // random: pool runs dry in some functions, cycles through in others
        while (queued < N_ITEMS / 2) add_function_run();
        wait_drained();     // sender holds off until everything has returned
        while (queued < N_ITEMS) add_function_run();
        wait_drained();

        repeat (NREGS + 32) @(negedge i_clk);
        if (grant_q.size() != 0) mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/lsra_pkg.sv
design/lsra_cell.sv
design/linear_scan_register_allocator_unit.sv
verif/linear_scan_register_allocator_unit_tb.sv
